### rtl/bmbm_pkg.sv
// Shared constants, types and the divisor reciprocal table for the block map box mean.
`default_nettype none

package bmbm_pkg;

	localparam int MAX_BLOCKS_DEF = 128;
	localparam int SCORE_BITS_DEF = 8;

	localparam int BPR_W = 8;
	localparam int MEAN_W = 8;
	localparam int COL_W = 8;

	localparam logic [BPR_W-1:0] BPR_RESET = 8'd128;
	localparam logic [BPR_W-1:0] BPR_MIN = 8'd4;

	localparam logic ACT_SCORE = 1'b0;
	localparam logic ACT_PAD = 1'b1;

	// Quotients come from a multiply by ceil(2^RECIP_SHIFT / divisor). With divisors of
	// at most 16 and window sums below 2^20 the truncated product is the exact quotient.
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W = RECIP_SHIFT + 1;

	typedef struct packed {
		logic       valid;
		logic       end_row;
		logic [2:0] nrows;
	} col_ctl_t;

	function automatic logic [RECIP_W-1:0] recip(input logic [4:0] div);
		logic [RECIP_W-1:0] r;
		case (div)
			5'd1:    r = 25'd16777216;
			5'd2:    r = 25'd8388608;
			5'd3:    r = 25'd5592406;
			5'd4:    r = 25'd4194304;
			5'd6:    r = 25'd2796203;
			5'd8:    r = 25'd2097152;
			5'd9:    r = 25'd1864136;
			5'd12:   r = 25'd1398102;
			5'd16:   r = 25'd1048576;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/bmbm_rows.sv
// Row history memory and the column sum stage: reads three rows above, adds them, writes back.
`default_nettype none

module bmbm_rows #(
	parameter int MAX_BLOCKS = bmbm_pkg::MAX_BLOCKS_DEF,
	parameter int SCORE_BITS = bmbm_pkg::SCORE_BITS_DEF,
	parameter int POS_W = 7
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic                     live_in,
	input  logic [SCORE_BITS-1:0]    score_in,
	input  logic [POS_W-1:0]         pos_in,
	input  logic                     end_in,
	input  logic                     s2_free,
	output logic                     busy,
	output bmbm_pkg::col_ctl_t       ctl,
	output logic [SCORE_BITS+1:0]    col,
	output logic [SCORE_BITS+1:0]    c0,
	output logic [SCORE_BITS+1:0]    c1,
	output logic [SCORE_BITS+1:0]    c2,
	output logic [POS_W-1:0]         pos
);
	import bmbm_pkg::*;

	localparam int SB = SCORE_BITS;
	localparam int CSW = SCORE_BITS + 2;

	// One word per column: the three previous rows, newest in the low bits.
	logic [3*SB-1:0] mem [MAX_BLOCKS];
	logic [3*SB-1:0] rdata_q;
	logic [3*SB-1:0] wdata;

	logic            valid_s1;
	logic            live_s1;
	logic [SB-1:0]   score_s1;
	logic [POS_W-1:0] pos_s1;
	logic            end_s1;

	logic [2:0]      hist_q;
	logic [CSW-1:0]  csum_q [3];

	logic            go;
	logic [SB-1:0]   row0, row1, row2;
	logic [2:0]      nrows;

	assign go = valid_s1 && s2_free;
	assign busy = valid_s1 && !s2_free;

	assign row0 = rdata_q[SB-1:0];
	assign row1 = rdata_q[2*SB-1:SB];
	assign row2 = rdata_q[3*SB-1:2*SB];
	assign wdata = {row1, row0, score_s1};

	// Rows that were padding hold nothing worth adding, so their entries are masked out.
	always_comb begin
		col = CSW'(score_s1)
			+ (hist_q[0] ? CSW'(row0) : '0)
			+ (hist_q[1] ? CSW'(row1) : '0)
			+ (hist_q[2] ? CSW'(row2) : '0);
		nrows = 3'(live_s1) + 3'(hist_q[0]) + 3'(hist_q[1]) + 3'(hist_q[2]);
	end

	// Adjacent items always sit in different columns, so the write-back never meets the
	// read of the following item.
	always_ff @(posedge clk) begin
		if (accept) begin
			rdata_q <= mem[pos_in];
		end
		if (go) begin
			mem[pos_s1] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			live_s1 <= live_in;
			score_s1 <= live_in ? score_in : '0;
			pos_s1 <= pos_in;
			end_s1 <= end_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			hist_q <= '0;
			csum_q[0] <= '0;
			csum_q[1] <= '0;
			csum_q[2] <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (go) begin
				valid_s1 <= 1'b0;
			end
			if (go) begin
				if (end_s1) begin
					hist_q <= {hist_q[1:0], live_s1};
					csum_q[0] <= '0;
					csum_q[1] <= '0;
					csum_q[2] <= '0;
				end else begin
					csum_q[0] <= col;
					csum_q[1] <= csum_q[0];
					csum_q[2] <= csum_q[1];
				end
			end
		end
	end

	assign ctl.valid = valid_s1;
	assign ctl.end_row = end_s1;
	assign ctl.nrows = nrows;
	assign c0 = csum_q[0];
	assign c1 = csum_q[1];
	assign c2 = csum_q[2];
	assign pos = pos_s1;

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && go) |-> (pos_in != pos_s1))
		else $error("row memory read and write-back hit the same column");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !go) |=> (valid_s1 && $stable(pos_s1) && $stable(score_s1)))
		else $error("column stage lost its item while waiting");

	a_hist_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(go && end_s1) |=> (hist_q[0] == $past(live_s1)))
		else $error("row history did not record the ending row");

endmodule

`default_nettype wire

### rtl/bmbm_emit.sv
// Result sequencer: window sums, divisor lookup, reciprocal multiply and output register.
`default_nettype none

module bmbm_emit #(
	parameter int MAX_BLOCKS = bmbm_pkg::MAX_BLOCKS_DEF,
	parameter int SCORE_BITS = bmbm_pkg::SCORE_BITS_DEF,
	parameter int POS_W = 7
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bmbm_pkg::col_ctl_t             ctl,
	input  logic [SCORE_BITS+1:0]          col,
	input  logic [SCORE_BITS+1:0]          c0,
	input  logic [SCORE_BITS+1:0]          c1,
	input  logic [SCORE_BITS+1:0]          c2,
	input  logic [POS_W-1:0]               pos,
	output logic                           s2_free,
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [bmbm_pkg::MEAN_W-1:0]    mean,
	output logic [bmbm_pkg::COL_W-1:0]     out_col,
	output logic                           last
);
	import bmbm_pkg::*;

	localparam int CSW = SCORE_BITS + 2;
	localparam int SUM_W = SCORE_BITS + 4;
	localparam int PROD_W = SUM_W + RECIP_W;
	localparam int OCW = (POS_W + 2 > COL_W) ? POS_W + 2 : COL_W;
	localparam logic [1:0] T_LAST = 2'd3;

	logic               valid_s2;
	logic               end_s2;
	logic [2:0]         nrows_s2;
	logic [POS_W-1:0]   pos_s2;
	logic [CSW-1:0]     col_s2;
	logic [CSW-1:0]     csum_s2 [3];
	logic [1:0]         t_q;

	logic               valid_s3;
	logic [SUM_W-1:0]   sum_s3;
	logic [RECIP_W-1:0] recip_s3;
	logic [COL_W-1:0]   col_s3;
	logic               last_s3;

	logic               out_valid_q;
	logic [MEAN_W-1:0]  mean_q;
	logic [COL_W-1:0]   col_q;
	logic               last_q;

	logic               out_free, s3_free, fire, final_res, load;
	logic [SUM_W-1:0]   sum3, sum2, sum1, sum0, sum_sel;
	logic [2:0]         want, ncols;
	logic [POS_W:0]     pos1;
	logic [5:0]         div6;
	logic [OCW-1:0]     oc;
	logic [PROD_W-1:0]  prod;

	assign out_free = !out_valid_q || !res_stall;
	assign s3_free = !valid_s3 || out_free;
	assign fire = valid_s2 && s3_free;
	// An item inside a row gives one result; the item that ends a row gives four.
	assign final_res = !end_s2 || (t_q == T_LAST);
	assign s2_free = !valid_s2 || (s3_free && final_res);
	assign load = ctl.valid && s2_free;

	always_comb begin
		sum3 = SUM_W'(col_s2);
		sum2 = sum3 + SUM_W'(csum_s2[0]);
		sum1 = sum2 + SUM_W'(csum_s2[1]);
		sum0 = sum1 + SUM_W'(csum_s2[2]);
		case (t_q)
			2'd0: begin
				sum_sel = sum0;
				want = 3'd4;
			end
			2'd1: begin
				sum_sel = sum1;
				want = 3'd3;
			end
			2'd2: begin
				sum_sel = sum2;
				want = 3'd2;
			end
			default: begin
				sum_sel = sum3;
				want = 3'd1;
			end
		endcase
		pos1 = (POS_W+1)'(pos_s2) + (POS_W+1)'(1);
		// Near the left edge fewer columns exist than the window wants.
		ncols = ((POS_W+1)'(want) > pos1) ? pos1[2:0] : want;
		div6 = {3'b000, nrows_s2} * {3'b000, ncols};
		oc = OCW'(pos_s2) + OCW'(t_q);
	end

	assign prod = PROD_W'(sum_s3) * PROD_W'(recip_s3);

	always_ff @(posedge clk) begin
		if (load) begin
			end_s2 <= ctl.end_row;
			nrows_s2 <= ctl.nrows;
			pos_s2 <= pos;
			col_s2 <= col;
			csum_s2[0] <= c0;
			csum_s2[1] <= c1;
			csum_s2[2] <= c2;
		end
		if (fire) begin
			sum_s3 <= sum_sel;
			recip_s3 <= recip(div6[4:0]);
			col_s3 <= oc[COL_W-1:0];
			last_s3 <= (t_q == T_LAST);
		end
		if (valid_s3 && out_free) begin
			mean_q <= prod[RECIP_SHIFT +: MEAN_W];
			col_q <= col_s3;
			last_q <= last_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			t_q <= '0;
			valid_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_s2 <= 1'b1;
				t_q <= '0;
			end else if (fire && final_res) begin
				valid_s2 <= 1'b0;
			end else if (fire) begin
				t_q <= t_q + 2'd1;
			end
			if (s3_free) begin
				valid_s3 <= fire;
			end
			if (out_free) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	assign res_valid = out_valid_q;
	assign mean = mean_q;
	assign out_col = col_q;
	assign last = last_q;

	a_tail_only_end: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && t_q != 2'd0) |-> end_s2)
		else $error("tail column sequenced for an item that does not end a row");

	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !out_free) |=> (valid_s3 && $stable(sum_s3) && $stable(col_s3)))
		else $error("multiply stage changed while the output was held");

	a_last_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && t_q == T_LAST) |=> (valid_s3 && last_s3))
		else $error("final tail column not marked as last");

endmodule

`default_nettype wire

### rtl/block_map_box_mean_4x4.sv
// Top level of the block map box mean: row length register, column counter and stage wiring.
`default_nettype none

// Causal 4x4 box mean over a raster stream of block scores. Within a row the input takes one
// score per cycle unless a stall on the output holds the result sequencer; the item that ends
// a row holds the result sequencer for its own column plus three tail columns, which stalls
// the input meanwhile. A transfer passes the column stage register, the result sequencer, the
// multiply register and the output register before its first result appears. The three
// previous rows live in one memory, one word per column. A word is read at the transfer and
// written back when the item moves on to the result sequencer. The memory needs no clearing
// pass, since rows not yet seen are masked by the row history. blocks_per_row is written
// through cfg_wr_en/cfg_wr_data; the user must write it only while the block is idle, which
// the block itself does not enforce. Values below 4 act as 4, above MAX_BLOCKS as MAX_BLOCKS.
module block_map_box_mean_4x4 #(
	parameter int MAX_BLOCKS = bmbm_pkg::MAX_BLOCKS_DEF,
	parameter int SCORE_BITS = bmbm_pkg::SCORE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [bmbm_pkg::BPR_W-1:0]    cfg_wr_data,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic                          action,
	input  logic [SCORE_BITS-1:0]         score,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [bmbm_pkg::MEAN_W-1:0]   mean,
	output logic [bmbm_pkg::COL_W-1:0]    out_col,
	output logic                          last
);
	import bmbm_pkg::*;

	localparam int POS_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = (POS_W >= BPR_W) ? POS_W + 1 : BPR_W + 1;

	logic [BPR_W-1:0]      bpr_q;
	logic [POS_W-1:0]      pos_q;
	logic [CW-1:0]         bpr_eff;
	logic [CW-1:0]         pos_next;
	logic                  row_end;
	logic                  accept;
	logic                  busy;
	logic                  s2_free;
	col_ctl_t              ctl;
	logic [SCORE_BITS+1:0] col, c0, c1, c2;
	logic [POS_W-1:0]      pos_s1;

	always_comb begin
		if (CW'(bpr_q) < CW'(BPR_MIN)) begin
			bpr_eff = CW'(BPR_MIN);
		end else if (CW'(bpr_q) > CW'(MAX_BLOCKS)) begin
			bpr_eff = CW'(MAX_BLOCKS);
		end else begin
			bpr_eff = CW'(bpr_q);
		end
		pos_next = CW'(pos_q) + CW'(1);
		// A shorter row length written mid-row ends the row at the next item.
		row_end = (pos_next >= bpr_eff);
	end

	assign item_stall = busy;
	assign accept = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpr_q <= BPR_RESET;
			pos_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				bpr_q <= cfg_wr_data;
			end
			if (accept) begin
				pos_q <= row_end ? '0 : pos_next[POS_W-1:0];
			end
		end
	end

	bmbm_rows #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.SCORE_BITS (SCORE_BITS),
		.POS_W      (POS_W)
	) u_rows (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.live_in  (action == ACT_SCORE),
		.score_in (score),
		.pos_in   (pos_q),
		.end_in   (row_end),
		.s2_free  (s2_free),
		.busy     (busy),
		.ctl      (ctl),
		.col      (col),
		.c0       (c0),
		.c1       (c1),
		.c2       (c2),
		.pos      (pos_s1)
	);

	bmbm_emit #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.SCORE_BITS (SCORE_BITS),
		.POS_W      (POS_W)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.col       (col),
		.c0        (c0),
		.c1        (c1),
		.c2        (c2),
		.pos       (pos_s1),
		.s2_free   (s2_free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.mean      (mean),
		.out_col   (out_col),
		.last      (last)
	);

endmodule

`default_nettype wire

### dv/block_map_box_mean_4x4_test.sv
// Self-checking testbench for the block map box mean: random frames against a window predictor.
module block_map_box_mean_4x4_test;
	import bmbm_pkg::*;

	localparam int NBLK = MAX_BLOCKS_DEF;
	localparam int SBITS = SCORE_BITS_DEF;

	typedef struct {
		logic             act;
		logic [SBITS-1:0] score;
	} score_item_t;

	typedef struct {
		logic [MEAN_W-1:0] mean;
		logic [COL_W-1:0]  col;
		logic              last;
	} box_mean_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wr_en = 1'b0;
	logic [BPR_W-1:0] cfg_wr_data = '0;
	logic             item_valid = 1'b0;
	logic             action = ACT_SCORE;
	logic [SBITS-1:0] score = '0;
	logic             res_stall = 1'b0;
	wire              item_stall;
	wire              res_valid;
	wire [MEAN_W-1:0] mean;
	wire [COL_W-1:0]  out_col;
	wire              last;

	block_map_box_mean_4x4 dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.action      (action),
		.score       (score),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.mean        (mean),
		.out_col     (out_col),
		.last        (last)
	);

	score_item_t      score_queue[$];
	box_mean_t        pending_means[$];
	int unsigned      items_queued = 0;
	bit               offering = 1'b0;
	int               mismatch_count = 0;
	int unsigned      cycle_no = 0;
	int               hold_left = 0;
	bit               long_hold_done = 1'b0;

	// Predictor state: three previous rows per column, realness of those rows, the
	// column sums of the last three columns of the current row and the row position.
	logic [SBITS-1:0] prev_rows [3][NBLK];
	logic [2:0]       row_was_real = '0;
	int unsigned      col_sums [3] = '{0, 0, 0};
	int unsigned      col_pos = 0;
	logic [BPR_W-1:0] row_len_reg = BPR_RESET;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#4000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	always @(posedge clk) cycle_no <= cycle_no + 1;

	function automatic bit calm_now();
		return cycle_no >= 700 && cycle_no < 1100;
	endfunction

	task automatic flag_mismatch(string what);
		mismatch_count++;
		$display("%0t: %s", $time, what);
	endtask

	function automatic void push_mean(int unsigned total, int unsigned nrows,
		int unsigned ncols, int unsigned col, logic fin);
		box_mean_t   e;
		int unsigned div;
		div = nrows * ncols;
		e.mean = (div != 0) ? MEAN_W'(total / div) : '0;
		e.col = COL_W'(col);
		e.last = fin;
		pending_means.push_back(e);
	endfunction

	function automatic void predict_box_mean(logic act, logic [SBITS-1:0] sc);
		int unsigned len, pos, colsum, nrows, total, ncols, want;
		int          r, t, i;
		logic        is_real;
		len = row_len_reg;
		if (len < 4)
			len = 4;
		if (len > NBLK)
			len = NBLK;
		is_real = (act == ACT_SCORE);
		pos = col_pos;
		if (pos >= NBLK)
			pos = NBLK - 1;
		colsum = is_real ? sc : 0;
		nrows = is_real;
		for (r = 0; r < 3; r++) begin
			if (row_was_real[r]) begin
				colsum += prev_rows[r][pos];
				nrows++;
			end
		end
		prev_rows[2][pos] = prev_rows[1][pos];
		prev_rows[1][pos] = prev_rows[0][pos];
		prev_rows[0][pos] = is_real ? sc : '0;
		total = colsum + col_sums[0] + col_sums[1] + col_sums[2];
		ncols = (pos + 1 > 4) ? 4 : pos + 1;
		push_mean(total, nrows, ncols, pos, 1'b0);
		col_sums[2] = col_sums[1];
		col_sums[1] = col_sums[0];
		col_sums[0] = colsum;
		// A row end also emits the three tail columns, each covering fewer columns.
		if (pos + 1 >= len) begin
			for (t = 1; t <= 3; t++) begin
				want = 4 - t;
				total = 0;
				for (i = 0; i < want; i++)
					total += col_sums[i];
				ncols = (want > pos + 1) ? pos + 1 : want;
				push_mean(total, nrows, ncols, pos + t, t == 3);
			end
			row_was_real = {row_was_real[1:0], is_real};
			col_sums = '{0, 0, 0};
			col_pos = 0;
		end else begin
			col_pos = pos + 1;
		end
	endfunction

	// Driver: take the handshake at the rising edge, offer the next item at the falling edge.
	always @(posedge clk) begin
		if (item_valid && !item_stall) begin
			predict_box_mean(action, score);
			offering = 1'b0;
		end
	end

	always @(negedge clk) begin
		score_item_t next_item;
		if (!offering) begin
			if (arst_n && score_queue.size() != 0
				&& (calm_now() || $urandom_range(0, 99) >= 27)) begin
				next_item = score_queue.pop_front();
				action <= next_item.act;
				score <= next_item.score;
				item_valid <= 1'b1;
				offering = 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Receiver stalls at random and now and then holds off long enough to back up the block.
	// The first long hold waits until plenty of items are queued, so the input really stalls.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			res_stall <= 1'b1;
		end else if (!long_hold_done && cycle_no >= 200 && score_queue.size() >= 16) begin
			long_hold_done = 1'b1;
			hold_left = $urandom_range(80, 150);
			res_stall <= 1'b1;
		end else if (!calm_now() && $urandom_range(0, 599) == 0) begin
			hold_left = $urandom_range(80, 150);
			res_stall <= 1'b1;
		end else begin
			res_stall <= !calm_now() && $urandom_range(0, 99) < 27;
		end
	end

	// Monitor: every result transfer is checked against the oldest expected mean.
	always @(posedge clk) begin
		box_mean_t oldest;
		if (res_valid && !res_stall) begin
			if (pending_means.size() == 0) begin
				flag_mismatch($sformatf("unexpected result: mean %0d col %0d last %0b",
					mean, out_col, last));
			end else begin
				oldest = pending_means.pop_front();
				if (mean !== oldest.mean)
					flag_mismatch($sformatf("col %0d: mean %0d, expected %0d",
						oldest.col, mean, oldest.mean));
				if (out_col !== oldest.col)
					flag_mismatch($sformatf("out_col %0d, expected %0d", out_col, oldest.col));
				if (last !== oldest.last)
					flag_mismatch($sformatf("col %0d: last %0b, expected %0b",
						oldest.col, last, oldest.last));
			end
		end
	end

	function automatic logic [SBITS-1:0] pick_score();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return SBITS'($urandom_range(0, (1 << SBITS) - 1));
		endcase
	endfunction

	function automatic void add_item(logic act, logic [SBITS-1:0] sc);
		score_item_t it;
		it.act = act;
		it.score = sc;
		score_queue.push_back(it);
		items_queued++;
	endfunction

	function automatic void add_row(int width, int pad_pct, int last_real_pct);
		int   c;
		logic act;
		for (c = 0; c < width; c++) begin
			if (c == width - 1)
				act = ($urandom_range(0, 99) < last_real_pct) ? ACT_SCORE : ACT_PAD;
			else
				act = ($urandom_range(0, 99) < pad_pct) ? ACT_PAD : ACT_SCORE;
			add_item(act, pick_score());
		end
	endfunction

	// A frame is a few mostly real rows followed by the three padding tail rows,
	// which leave no real row in the history.
	function automatic void add_frame(int width, int rows, int pad_pct);
		repeat (rows) add_row(width, pad_pct, 85);
		repeat (3) add_row(width, 100, 0);
	endfunction

	task automatic drain();
		while (score_queue.size() != 0 || offering || pending_means.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_row_len(logic [BPR_W-1:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		row_len_reg = v;
	endtask

	initial begin
		int unsigned      start_count;
		logic [BPR_W-1:0] v;
		int               w;
		foreach (prev_rows[r, c])
			prev_rows[r][c] = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed rows at the shortest row length, written below the legal range.
		set_row_len(BPR_W'(2));
		add_item(ACT_PAD, '0);
		repeat (3) add_item(ACT_SCORE, '1);
		add_item(ACT_PAD, '1);
		add_item(ACT_SCORE, '0);
		add_item(ACT_SCORE, '1);
		add_item(ACT_PAD, SBITS'(128));
		add_item(ACT_SCORE, SBITS'(1));
		add_item(ACT_SCORE, SBITS'(254));
		add_item(ACT_SCORE, '0);
		add_item(ACT_SCORE, '1);
		repeat (3) add_row(4, 100, 0);
		drain();

		// Shrink the row length while the block is parked mid-row past the new end.
		set_row_len(BPR_W'(9));
		repeat (7) add_item(ACT_SCORE, pick_score());
		drain();
		set_row_len(BPR_W'(6));
		add_item(ACT_SCORE, pick_score());
		add_frame(6, 3, 10);
		drain();

		set_row_len(BPR_MIN);
		add_frame(4, 4, 10);
		drain();

		start_count = items_queued;
		while (items_queued - start_count < 150) begin
			v = ($urandom_range(0, 5) == 0) ? BPR_W'($urandom_range(0, 3))
				: BPR_W'($urandom_range(4, 24));
			set_row_len(v);
			w = (v < 4) ? 4 : v;
			repeat ($urandom_range(1, 2)) add_frame(w, $urandom_range(1, 5), 10);
			drain();
		end

		// Widest rows: once at the limit and once written above it.
		set_row_len(BPR_W'(NBLK));
		add_row(NBLK, 10, 85);
		drain();
		set_row_len('1);
		add_row(NBLK, 10, 85);
		drain();

		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
